FILE: hw/rtl/irsm_pkg.sv
// Shared types, codes and default sizes for the integer range set merge block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package irsm_pkg;

  localparam int DEF_MAX_RANGES = 64;
  localparam int DEF_VALUE_BITS = 32;

  localparam int KIND_W   = 3;
  localparam int BOUND_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 33;

  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESTRICT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PROBE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic rd_en;
    logic step;
    logic fin;
    logic commit;
    logic load_out;
  } irsm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_req;
    logic read_req;
    logic read_mode;
    logic adv;
    logic last;
  } irsm_sts_t;

endpackage

FILE: hw/rtl/irsm_item_if.sv
// Channel carrying one request into the range set block.
// Depends on irsm_pkg for the field widths.
`timescale 1ns / 1ps

interface irsm_item_if
  import irsm_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic        [KIND_W-1:0]   kind;
  logic signed [BOUND_W-1:0]  range_lo;
  logic signed [BOUND_W-1:0]  range_hi;
  logic        [INDEX_W-1:0]  entry_index;

  modport source (output valid, kind, range_lo, range_hi, entry_index, input ready);
  modport sink   (input valid, kind, range_lo, range_hi, entry_index, output ready);
endinterface

FILE: hw/rtl/irsm_result_if.sv
// Channel carrying one result out of the range set block.
// Depends on irsm_pkg for the field widths.
`timescale 1ns / 1ps

interface irsm_result_if
  import irsm_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic signed [BOUND_W-1:0]  out_lo;
  logic signed [BOUND_W-1:0]  out_hi;
  logic        [COUNT_W-1:0]  range_count;
  logic        [TOTAL_W-1:0]  element_total;

  modport source (output valid, status, out_lo, out_hi, range_count, element_total,
                  input ready);
  modport sink   (input valid, status, out_lo, out_hi, range_count, element_total,
                  output ready);
endinterface

FILE: hw/rtl/integer_range_set_merge_core.sv
// Top level of the integer range set merge block.
// Depends on irsm_pkg, irsm_item_if, irsm_result_if, irsm_ctrl and irsm_dp.
`timescale 1ns / 1ps

// The block keeps a sorted table of disjoint, non-adjacent integer ranges.
// Requests arrive on the item channel (kind, range_lo, range_hi, entry_index)
// and each one produces exactly one result on the result channel (status,
// out_lo, out_hi, range_count, element_total). Both channels use valid/ready;
// a request moves when valid and ready are high at the same rising edge.
// Kinds are insert, restrict, clear, probe and read entry.
// The table lives in two banks of one memory. Insert and restrict stream the
// live bank through the merge logic one entry at a time (read, then
// evaluate) and write the rebuilt table into the other bank, which then
// becomes live; an insert that would overflow simply leaves the banks alone.
// A scanning request reads and then evaluates each stored entry in turn, with
// one more evaluate step when an insert places its range in front of a stored
// entry; clear, read and requests that need no scan do without the scan.
// A request is taken only once the previous one is done: the next request is
// accepted as soon as the previous result sits in the output register, so a
// stalled receiver only holds the block once a second result is ready.
// Reset is synchronous and leaves the set empty; no clearing pass is needed.

module integer_range_set_merge_core
  import irsm_pkg::*;
  #(
  parameter int MAX_RANGES = DEF_MAX_RANGES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic            clk,
  input logic            rst,
  irsm_item_if.sink      item,
  irsm_result_if.source  result
);

  irsm_cmd_t cmd;
  irsm_sts_t sts;

  // The controller owns sequencing and the result valid flag.
  irsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath owns the table, the merge logic and the result payload.
  irsm_dp #(
    .MAX_RANGES (MAX_RANGES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (item.kind),
    .in_lo      (item.range_lo),
    .in_hi      (item.range_hi),
    .in_index   (item.entry_index),
    .res_status (result.status),
    .res_lo     (result.out_lo),
    .res_hi     (result.out_hi),
    .res_count  (result.range_count),
    .res_total  (result.element_total)
  );

endmodule

FILE: hw/rtl/irsm_ctrl.sv
// Sequencing state machine of the range set block.
// Depends on irsm_pkg for the command and status structs.
`timescale 1ns / 1ps

module irsm_ctrl
  import irsm_pkg::*;
  (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  irsm_sts_t sts,
  output irsm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_PROC   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = (sts.scan_req || sts.read_req) ? S_RD : S_FIN;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_PROC;
      end
      S_PROC: begin
        if (sts.read_mode) begin
          state_next = S_OUT;
        end else begin
          cmd.step = 1'b1;
          if (sts.adv) begin
            state_next = sts.last ? S_FIN : S_RD;
          end
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result loaded over an unread result");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECODE))
    else $error("accepted request not decoded");

  a_read_goes_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC && sts.read_mode) |=> (state == S_OUT))
    else $error("entry read did not go to output");

endmodule

FILE: hw/rtl/irsm_dp.sv
// Datapath of the range set block: double-banked range table, scan and merge
// logic, running hull and element total, and the result register.
// Depends on irsm_pkg for codes, widths and the command and status structs.
`timescale 1ns / 1ps

module irsm_dp
  import irsm_pkg::*;
  #(
  parameter int MAX_RANGES = DEF_MAX_RANGES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  irsm_cmd_t                  cmd,
  output irsm_sts_t                  sts,
  input  logic        [KIND_W-1:0]   in_kind,
  input  logic signed [BOUND_W-1:0]  in_lo,
  input  logic signed [BOUND_W-1:0]  in_hi,
  input  logic        [INDEX_W-1:0]  in_index,
  output logic        [STATUS_W-1:0] res_status,
  output logic signed [BOUND_W-1:0]  res_lo,
  output logic signed [BOUND_W-1:0]  res_hi,
  output logic        [COUNT_W-1:0]  res_count,
  output logic        [TOTAL_W-1:0]  res_total
);

  localparam int IDX_W  = $clog2(MAX_RANGES);
  localparam int CNT_W  = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int VW     = VALUE_BITS;
  localparam int XW     = VALUE_BITS + 1;
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic signed [63:0] VAL_TOP = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] VAL_BOT = -VAL_TOP - 64'sd1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

  // Two banks: the live table and the one being rebuilt.
  logic signed [VW-1:0] mem_lo [DEPTH];
  logic signed [VW-1:0] mem_hi [DEPTH];

  logic        [KIND_W-1:0]  op_kind;
  logic signed [VW-1:0]      op_lo;
  logic signed [VW-1:0]      op_hi;
  logic        [INDEX_W-1:0] op_idx;
  logic                      op_empty;
  logic                      bank;
  logic        [CNT_W-1:0]   count;
  logic        [CNT_W-1:0]   rptr;
  logic        [CNT_W-1:0]   wptr;
  logic signed [VW-1:0]      hull_lo;
  logic signed [VW-1:0]      hull_hi;
  logic        [XW-1:0]      total;
  logic        [XW-1:0]      acc_total;
  logic signed [VW-1:0]      first_lo;
  logic signed [VW-1:0]      last_hi;
  logic                      placed;
  logic                      merged;
  logic                      found;
  logic                      dropped;
  logic signed [VW-1:0]      pr_lo;
  logic signed [VW-1:0]      pr_hi;
  logic signed [VW-1:0]      rd_lo;
  logic signed [VW-1:0]      rd_hi;

  logic signed [63:0]        lo_ext;
  logic signed [63:0]        hi_ext;
  logic signed [63:0]        lo_sat;
  logic signed [63:0]        hi_sat;
  logic        [CMP_W-1:0]   idx_c;
  logic                      idx_ok;
  logic        [ADDR_W-1:0]  rd_addr;
  logic signed [XW-1:0]      e_lo_x;
  logic signed [XW-1:0]      e_hi_x;
  logic signed [XW-1:0]      op_lo_x;
  logic signed [XW-1:0]      op_hi_x;
  logic                      below;
  logic                      above;
  logic signed [VW-1:0]      il;
  logic signed [VW-1:0]      ih;
  logic                      meets;
  logic                      wr_en;
  logic signed [VW-1:0]      wr_lo;
  logic signed [VW-1:0]      wr_hi;
  logic        [XW-1:0]      wr_span;
  logic signed [63:0]        o_lo_ext;
  logic signed [63:0]        o_hi_ext;
  logic        [STATUS_W-1:0] o_status;
  logic signed [VW-1:0]      o_lo;
  logic signed [VW-1:0]      o_hi;
  logic        [63:0]        cnt_ext;
  logic        [63:0]        tot_ext;
  logic                      is_ins;
  logic                      is_res;
  logic                      is_probe;

  // Saturate the operand bounds to the stored value range.
  always_comb begin
    lo_ext = 64'(in_lo);
    hi_ext = 64'(in_hi);
    lo_sat = (lo_ext > VAL_TOP) ? VAL_TOP : ((lo_ext < VAL_BOT) ? VAL_BOT : lo_ext);
    hi_sat = (hi_ext > VAL_TOP) ? VAL_TOP : ((hi_ext < VAL_BOT) ? VAL_BOT : hi_ext);
  end

  assign is_ins   = (op_kind == KIND_INSERT);
  assign is_res   = (op_kind == KIND_RESTRICT);
  assign is_probe = (op_kind == KIND_PROBE);

  assign idx_c  = CMP_W'(op_idx);
  assign idx_ok = idx_c < CMP_W'(count);
  assign rd_addr = sts.read_mode ? {bank, idx_c[IDX_W-1:0]} : {bank, rptr[IDX_W-1:0]};

  assign e_lo_x  = XW'(rd_lo);
  assign e_hi_x  = XW'(rd_hi);
  assign op_lo_x = XW'(op_lo);
  assign op_hi_x = XW'(op_hi);
  assign below   = (e_hi_x + XW'(1)) < op_lo_x;
  assign above   = e_lo_x > (op_hi_x + XW'(1));
  assign il      = (rd_lo > op_lo) ? rd_lo : op_lo;
  assign ih      = (rd_hi < op_hi) ? rd_hi : op_hi;
  assign meets   = (rd_hi >= op_lo) && (rd_lo <= op_hi);

  always_comb begin
    sts.scan_req  = (count != '0) && !op_empty && (is_ins || is_res || is_probe);
    sts.read_mode = (op_kind == KIND_READ);
    sts.read_req  = sts.read_mode && idx_ok;
    sts.adv       = !(is_ins && !placed && !below && above);
    sts.last      = ({1'b0, rptr} + 1'b1) == {1'b0, count};
  end

  // Write selection: one entry of the rebuilt bank per cycle at most.
  always_comb begin
    wr_en = 1'b0;
    wr_lo = rd_lo;
    wr_hi = rd_hi;
    if (cmd.step) begin
      if (is_ins) begin
        if (placed || below) begin
          wr_en = 1'b1;
        end else if (above) begin
          wr_en = 1'b1;
          wr_lo = op_lo;
          wr_hi = op_hi;
        end
      end else if (is_res) begin
        wr_en = (il <= ih);
        wr_lo = il;
        wr_hi = ih;
      end
    end else if (cmd.fin) begin
      wr_en = is_ins && !op_empty && !placed;
      wr_lo = op_lo;
      wr_hi = op_hi;
    end
  end

  assign wr_span = XW'(wr_hi) - XW'(wr_lo) + XW'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_lo <= mem_lo[rd_addr];
      rd_hi <= mem_hi[rd_addr];
    end
    if (wr_en && (wptr < CNT_MAX)) begin
      mem_lo[{~bank, wptr[IDX_W-1:0]}] <= wr_lo;
      mem_hi[{~bank, wptr[IDX_W-1:0]}] <= wr_hi;
    end
  end

  // Operand, scan pointers and accumulators.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_kind   <= in_kind;
      op_lo     <= lo_sat[VW-1:0];
      op_hi     <= hi_sat[VW-1:0];
      op_idx    <= in_index;
      op_empty  <= lo_sat > hi_sat;
      rptr      <= '0;
      wptr      <= '0;
      acc_total <= '0;
      placed    <= 1'b0;
      merged    <= 1'b0;
      found     <= 1'b0;
      dropped   <= 1'b0;
    end else begin
      if (wr_en) begin
        if (wptr == '0) begin
          first_lo <= wr_lo;
        end
        last_hi   <= wr_hi;
        acc_total <= acc_total + wr_span;
        if (wptr != CNT_MAX) begin
          wptr <= wptr + 1'b1;
        end
      end
      if (cmd.step) begin
        if (sts.adv) begin
          rptr <= rptr + 1'b1;
        end
        if (is_ins && !placed && !below) begin
          if (above) begin
            placed <= 1'b1;
          end else begin
            op_lo  <= (rd_lo < op_lo) ? rd_lo : op_lo;
            op_hi  <= (rd_hi > op_hi) ? rd_hi : op_hi;
            merged <= 1'b1;
          end
        end
        if (is_probe && meets) begin
          if (!found) begin
            pr_lo <= il;
          end
          pr_hi <= ih;
          found <= 1'b1;
        end
      end
      if (cmd.commit && is_ins && !op_empty && !merged && (count >= CNT_MAX)) begin
        dropped <= 1'b1;
      end
    end
  end

  // Live table state: bank select, count, hull and element total.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
      total <= '0;
    end else if (cmd.commit) begin
      if ((is_ins && !op_empty && (merged || (count < CNT_MAX))) ||
          (is_res && !op_empty)) begin
        bank    <= ~bank;
        count   <= wptr;
        total   <= acc_total;
        hull_lo <= first_lo;
        hull_hi <= last_hi;
      end else if (is_res || (op_kind == KIND_CLEAR)) begin
        count <= '0;
        total <= '0;
      end
    end
  end

  // Result selection.
  always_comb begin
    o_status = ST_OK;
    o_lo     = '0;
    o_hi     = '0;
    case (op_kind)
      KIND_PROBE: begin
        if (found) begin
          o_lo = pr_lo;
          o_hi = pr_hi;
        end else begin
          o_status = ST_EMPTY;
        end
      end
      KIND_READ: begin
        if (idx_ok) begin
          o_lo = rd_lo;
          o_hi = rd_hi;
        end else begin
          o_status = ST_BAD_INDEX;
        end
      end
      default: begin
        if (count == '0) begin
          o_status = dropped ? ST_FULL : ST_EMPTY;
        end else begin
          o_status = dropped ? ST_FULL : ST_OK;
          o_lo     = hull_lo;
          o_hi     = hull_hi;
        end
      end
    endcase
    o_lo_ext = 64'(o_lo);
    o_hi_ext = 64'(o_hi);
    cnt_ext  = 64'(count);
    tot_ext  = 64'(total);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_status <= o_status;
      res_lo     <= o_lo_ext[BOUND_W-1:0];
      res_hi     <= o_hi_ext[BOUND_W-1:0];
      res_count  <= cnt_ext[COUNT_W-1:0];
      res_total  <= tot_ext[TOTAL_W-1:0];
    end
  end

endmodule
